>>> hdl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants for the triplet to compressed-column converter.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = ENTRY_AW + 1;
  localparam int MAX_COLUMNS = 256;
  localparam int COL_W       = 8;
  localparam int NCOL_W      = 9;
  localparam int ROW_W       = 16;
  localparam int VAL_W       = 32;
  localparam int KEY_W       = COL_W + ROW_W;

  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_BUILD    = 3'd1;
  localparam logic [2:0] OP_RD_START = 3'd2;
  localparam logic [2:0] OP_RD_ENTRY = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [ROW_W-1:0]        row_index;
    logic [COL_W-1:0]        column_index;
    logic signed [VAL_W-1:0] entry_value;
    logic [10:0]             read_index;
  } item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [CNT_W-1:0]        number;
    logic [ROW_W-1:0]        out_row;
    logic signed [VAL_W-1:0] out_value;
  } result_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_ITEM,
    DP_COPY_RD,
    DP_COPY_WR,
    DP_SORT_INIT,
    DP_SORT_RD,
    DP_SORT_HOLD,
    DP_SORT_CMP_RD,
    DP_SORT_CMP,
    DP_MERGE_INIT,
    DP_MERGE_RD,
    DP_MERGE,
    DP_TAIL,
    DP_FINISH
  } dp_cmd_t;

  typedef struct packed {
    logic build_go;
    logic a_eq_n;
    logic a_ge_n;
    logic b_zero;
    logic shift_gt;
    logic col_pending;
    logic tail_done;
  } dp_status_t;

endpackage

>>> hdl/stc_ctrl.sv
// ----------------------------------------------------------------------------
// stc_ctrl
// Sequencer: takes commands and walks the build through copy, sort and merge.
// ----------------------------------------------------------------------------
module stc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  stc_pkg::dp_status_t sts,
  output stc_pkg::dp_cmd_t    cmd,
  output logic                busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_COPY_RD,
    S_COPY_WR,
    S_SORT_RD,
    S_SORT_HOLD,
    S_SORT_CMP_RD,
    S_SORT_CMP,
    S_MERGE_RD,
    S_MERGE,
    S_TAIL
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = stc_pkg::DP_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd = stc_pkg::DP_ITEM;
          if (sts.build_go) state_next = S_COPY_RD;
        end
      end
      S_COPY_RD: begin
        if (sts.a_eq_n) begin
          cmd        = stc_pkg::DP_SORT_INIT;
          state_next = S_SORT_RD;
        end else begin
          cmd        = stc_pkg::DP_COPY_RD;
          state_next = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        cmd        = stc_pkg::DP_COPY_WR;
        state_next = S_COPY_RD;
      end
      S_SORT_RD: begin
        if (sts.a_ge_n) begin
          cmd        = stc_pkg::DP_MERGE_INIT;
          state_next = S_MERGE_RD;
        end else begin
          cmd        = stc_pkg::DP_SORT_RD;
          state_next = S_SORT_HOLD;
        end
      end
      S_SORT_HOLD: begin
        cmd        = stc_pkg::DP_SORT_HOLD;
        state_next = S_SORT_CMP_RD;
      end
      S_SORT_CMP_RD: begin
        cmd        = stc_pkg::DP_SORT_CMP_RD;
        state_next = sts.b_zero ? S_SORT_RD : S_SORT_CMP;
      end
      S_SORT_CMP: begin
        cmd        = stc_pkg::DP_SORT_CMP;
        state_next = sts.shift_gt ? S_SORT_CMP_RD : S_SORT_RD;
      end
      S_MERGE_RD: begin
        if (sts.a_eq_n) begin
          state_next = S_TAIL;
        end else begin
          cmd        = stc_pkg::DP_MERGE_RD;
          state_next = S_MERGE;
        end
      end
      S_MERGE: begin
        cmd        = stc_pkg::DP_MERGE;
        state_next = sts.col_pending ? S_MERGE : S_MERGE_RD;
      end
      S_TAIL: begin
        if (sts.tail_done) begin
          cmd        = stc_pkg::DP_FINISH;
          state_next = S_IDLE;
        end else begin
          cmd = stc_pkg::DP_TAIL;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

>>> hdl/stc_datapath.sv
// ----------------------------------------------------------------------------
// stc_datapath
// Triplet store, work store for sorting, packed entries, column starts and
// the counters and result register driven by the sequencer.
// ----------------------------------------------------------------------------
module stc_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  stc_pkg::dp_cmd_t                      cmd,
  input  stc_pkg::item_t                        item,
  input  logic                                  cfg_valid,
  input  logic [stc_pkg::NCOL_W-1:0]            cfg_data,
  output stc_pkg::dp_status_t                   sts,
  output logic                                  done,
  output stc_pkg::result_t                      result
);

  typedef struct packed {
    logic [stc_pkg::COL_W-1:0]        col;
    logic [stc_pkg::ROW_W-1:0]        row;
    logic signed [stc_pkg::VAL_W-1:0] val;
  } trip_t;

  typedef struct packed {
    logic [stc_pkg::ROW_W-1:0]        row;
    logic signed [stc_pkg::VAL_W-1:0] val;
  } entry_t;

  typedef enum logic [1:0] {
    SEL_REG,
    SEL_START,
    SEL_ENTRY
  } res_sel_t;

  function automatic logic signed [stc_pkg::VAL_W-1:0] sat_add(
    input logic signed [stc_pkg::VAL_W-1:0] x,
    input logic signed [stc_pkg::VAL_W-1:0] y
  );
    logic signed [stc_pkg::VAL_W:0] s;
    s = {x[stc_pkg::VAL_W-1], x} + {y[stc_pkg::VAL_W-1], y};
    if (s[stc_pkg::VAL_W] != s[stc_pkg::VAL_W-1]) begin
      sat_add = s[stc_pkg::VAL_W] ? {1'b1, {(stc_pkg::VAL_W-1){1'b0}}}
                                  : {1'b0, {(stc_pkg::VAL_W-1){1'b1}}};
    end else begin
      sat_add = s[stc_pkg::VAL_W-1:0];
    end
  endfunction

  // memories
  trip_t                     trip_mem  [stc_pkg::MAX_ENTRIES];
  trip_t                     work_mem  [stc_pkg::MAX_ENTRIES];
  entry_t                    packed_mem[stc_pkg::MAX_ENTRIES];
  logic [stc_pkg::CNT_W-1:0] start_mem [stc_pkg::MAX_COLUMNS+1];

  trip_t                     trip_rd;
  trip_t                     work_rd;
  entry_t                    packed_rd;
  logic [stc_pkg::CNT_W-1:0] start_rd;

  // control and working registers
  logic [stc_pkg::NCOL_W-1:0] num_columns;
  logic [stc_pkg::CNT_W-1:0]  trip_count;
  logic [stc_pkg::COL_W-1:0]  max_col;
  logic                       built;
  logic [stc_pkg::NCOL_W-1:0] built_columns;
  logic [stc_pkg::CNT_W-1:0]  uniq;
  logic [stc_pkg::CNT_W-1:0]  a;
  logic [stc_pkg::CNT_W-1:0]  b;
  logic [stc_pkg::CNT_W-1:0]  w;
  logic [stc_pkg::NCOL_W-1:0] jc;
  trip_t                      hold;
  logic [stc_pkg::KEY_W-1:0]  prev_key;
  logic signed [stc_pkg::VAL_W-1:0] acc;
  logic [1:0]                 res_status;
  logic [stc_pkg::CNT_W-1:0]  res_number;
  res_sel_t                   res_sel;

  logic [stc_pkg::NCOL_W-1:0] ncol;
  logic                       add_ok;
  logic                       stale;
  logic                       dup;
  logic signed [stc_pkg::VAL_W-1:0] merged;

  logic                              work_we;
  logic [stc_pkg::ENTRY_AW-1:0]      work_waddr;
  trip_t                             work_wdata;
  logic                              work_re;
  logic [stc_pkg::ENTRY_AW-1:0]      work_raddr;
  logic                              packed_we;
  logic [stc_pkg::ENTRY_AW-1:0]      packed_waddr;
  entry_t                            packed_wdata;
  logic                              start_we;
  logic                              item_rd_start;
  logic                              item_rd_entry;
  logic [stc_pkg::CNT_W-1:0]         idx;

  assign ncol = (num_columns > stc_pkg::NCOL_W'(stc_pkg::MAX_COLUMNS))
              ? stc_pkg::NCOL_W'(stc_pkg::MAX_COLUMNS) : num_columns;
  assign idx  = item.read_index;
  assign add_ok = (trip_count != stc_pkg::CNT_W'(stc_pkg::MAX_ENTRIES))
               && ({1'b0, item.column_index} < ncol);
  // a stored column at or above the columns in use blocks the build
  assign stale = (trip_count != '0) && ({1'b0, max_col} >= ncol);
  assign dup   = (a != '0) && ({work_rd.col, work_rd.row} == prev_key);
  assign merged = sat_add(acc, work_rd.val);

  assign item_rd_start = (cmd == stc_pkg::DP_ITEM) && (item.opcode == stc_pkg::OP_RD_START)
                      && built && (idx <= {2'b0, built_columns});
  assign item_rd_entry = (cmd == stc_pkg::DP_ITEM) && (item.opcode == stc_pkg::OP_RD_ENTRY)
                      && built && (idx < uniq);

  always_comb begin
    sts.build_go    = (item.opcode == stc_pkg::OP_BUILD) && !stale;
    sts.a_eq_n      = (a == trip_count);
    sts.a_ge_n      = (a >= trip_count);
    sts.b_zero      = (b == '0);
    sts.shift_gt    = {work_rd.col, work_rd.row} > {hold.col, hold.row};
    sts.col_pending = (jc <= {1'b0, work_rd.col});
    sts.tail_done   = (jc > ncol);
  end

  always_comb begin
    work_we      = 1'b0;
    work_waddr   = a[stc_pkg::ENTRY_AW-1:0];
    work_wdata   = trip_rd;
    work_re      = 1'b0;
    work_raddr   = a[stc_pkg::ENTRY_AW-1:0];
    packed_we    = 1'b0;
    packed_waddr = w[stc_pkg::ENTRY_AW-1:0];
    packed_wdata = '{row: work_rd.row, val: work_rd.val};
    start_we     = 1'b0;
    case (cmd)
      stc_pkg::DP_COPY_WR: begin
        work_we = 1'b1;
      end
      stc_pkg::DP_SORT_RD, stc_pkg::DP_MERGE_RD: begin
        work_re = 1'b1;
      end
      stc_pkg::DP_SORT_CMP_RD: begin
        if (b == '0) begin
          work_we    = 1'b1;
          work_waddr = '0;
          work_wdata = hold;
        end else begin
          work_re    = 1'b1;
          work_raddr = stc_pkg::ENTRY_AW'(b - 1'b1);
        end
      end
      stc_pkg::DP_SORT_CMP: begin
        work_we    = 1'b1;
        work_waddr = b[stc_pkg::ENTRY_AW-1:0];
        work_wdata = sts.shift_gt ? work_rd : hold;
      end
      stc_pkg::DP_MERGE: begin
        if (sts.col_pending) begin
          start_we = 1'b1;
        end else begin
          packed_we = 1'b1;
          if (dup) begin
            packed_waddr = stc_pkg::ENTRY_AW'(w - 1'b1);
            packed_wdata = '{row: work_rd.row, val: merged};
          end
        end
      end
      stc_pkg::DP_TAIL: begin
        start_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if ((cmd == stc_pkg::DP_ITEM) && (item.opcode == stc_pkg::OP_ADD) && add_ok) begin
      trip_mem[trip_count[stc_pkg::ENTRY_AW-1:0]] <=
        '{col: item.column_index, row: item.row_index, val: item.entry_value};
    end
    if (cmd == stc_pkg::DP_COPY_RD) begin
      trip_rd <= trip_mem[a[stc_pkg::ENTRY_AW-1:0]];
    end
    if (work_we) work_mem[work_waddr] <= work_wdata;
    if (work_re) work_rd <= work_mem[work_raddr];
    if (packed_we) packed_mem[packed_waddr] <= packed_wdata;
    if (item_rd_entry) packed_rd <= packed_mem[idx[stc_pkg::ENTRY_AW-1:0]];
    if (start_we) start_mem[jc] <= w;
    if (item_rd_start) start_rd <= start_mem[idx[stc_pkg::NCOL_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_columns <= stc_pkg::NCOL_W'(stc_pkg::MAX_COLUMNS);
      trip_count  <= '0;
      built       <= 1'b0;
      done        <= 1'b0;
      res_sel     <= SEL_REG;
    end else begin
      // a started build answers only when it finishes
      done <= ((cmd == stc_pkg::DP_ITEM) && !sts.build_go) || (cmd == stc_pkg::DP_FINISH);
      if (cfg_valid) num_columns <= cfg_data;
      case (cmd)
        stc_pkg::DP_ITEM: begin
          res_sel <= item_rd_start ? SEL_START : (item_rd_entry ? SEL_ENTRY : SEL_REG);
          case (item.opcode)
            stc_pkg::OP_ADD: begin
              if (trip_count == stc_pkg::CNT_W'(stc_pkg::MAX_ENTRIES)) begin
                res_status <= stc_pkg::ST_FULL;
                res_number <= trip_count;
              end else if (!add_ok) begin
                res_status <= stc_pkg::ST_RANGE;
                res_number <= trip_count;
              end else begin
                res_status <= stc_pkg::ST_OK;
                res_number <= trip_count + 1'b1;
                trip_count <= trip_count + 1'b1;
                built      <= 1'b0;
                if (trip_count == '0 || item.column_index > max_col) begin
                  max_col <= item.column_index;
                end
              end
            end
            stc_pkg::OP_BUILD: begin
              if (stale) begin
                built      <= 1'b0;
                res_status <= stc_pkg::ST_RANGE;
                res_number <= trip_count;
              end else begin
                a <= '0;
              end
            end
            stc_pkg::OP_RD_START: begin
              if (!built) begin
                res_status <= stc_pkg::ST_NOT_BUILT;
                res_number <= '0;
              end else if (!item_rd_start) begin
                res_status <= stc_pkg::ST_RANGE;
                res_number <= uniq;
              end else begin
                res_status <= stc_pkg::ST_OK;
              end
            end
            stc_pkg::OP_RD_ENTRY: begin
              if (!built) begin
                res_status <= stc_pkg::ST_NOT_BUILT;
                res_number <= '0;
              end else begin
                res_number <= uniq;
                if (!item_rd_entry) begin
                  res_status <= stc_pkg::ST_RANGE;
                end else begin
                  res_status <= stc_pkg::ST_OK;
                end
              end
            end
            stc_pkg::OP_CLEAR: begin
              trip_count <= '0;
              built      <= 1'b0;
              res_status <= stc_pkg::ST_OK;
              res_number <= '0;
            end
            default: begin
              res_status <= stc_pkg::ST_RANGE;
              res_number <= '0;
            end
          endcase
        end
        stc_pkg::DP_COPY_WR: begin
          a <= a + 1'b1;
        end
        stc_pkg::DP_SORT_INIT: begin
          a <= stc_pkg::CNT_W'(1);
        end
        stc_pkg::DP_SORT_HOLD: begin
          hold <= work_rd;
          b    <= a;
        end
        stc_pkg::DP_SORT_CMP_RD: begin
          if (b == '0) a <= a + 1'b1;
        end
        stc_pkg::DP_SORT_CMP: begin
          if (sts.shift_gt) begin
            b <= b - 1'b1;
          end else begin
            a <= a + 1'b1;
          end
        end
        stc_pkg::DP_MERGE_INIT: begin
          a  <= '0;
          w  <= '0;
          jc <= '0;
        end
        stc_pkg::DP_MERGE: begin
          if (sts.col_pending) begin
            jc <= jc + 1'b1;
          end else begin
            prev_key <= {work_rd.col, work_rd.row};
            a        <= a + 1'b1;
            if (dup) begin
              acc <= merged;
            end else begin
              acc <= work_rd.val;
              w   <= w + 1'b1;
            end
          end
        end
        stc_pkg::DP_TAIL: begin
          jc <= jc + 1'b1;
        end
        stc_pkg::DP_FINISH: begin
          built         <= 1'b1;
          built_columns <= ncol;
          uniq          <= w;
          res_status    <= stc_pkg::ST_OK;
          res_number    <= w;
          res_sel       <= SEL_REG;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.status    = res_status;
    result.number    = (res_sel == SEL_START) ? start_rd : res_number;
    result.out_row   = (res_sel == SEL_ENTRY) ? packed_rd.row : '0;
    result.out_value = (res_sel == SEL_ENTRY) ? packed_rd.val : '0;
  end

endmodule

>>> hdl/sparse_triplet_to_csc_top.sv
// ----------------------------------------------------------------------------
// sparse_triplet_to_csc_top
// Converts stored (row, column, value) triplets to compressed sparse columns.
// ----------------------------------------------------------------------------
// A command word on item is taken when start is high and busy is low. Its
// result appears on result for one cycle with done high, the cycle after the
// command for add, read column start, read entry, clear and rejected builds;
// these run one per cycle. The receiver cannot hold results off.
// A build copies the n stored triplets to a work store, sorts them by column
// then row with an insertion sort on that store's single read port, then
// merges duplicates and writes the column starts. busy stays high meanwhile
// and the result arrives with done as it drops.
// num_columns is written on cfg_data with cfg_valid and cfg_ready is always
// high. The user makes writes only while idle; the block does not enforce it.
// After reset the store is empty, nothing is built and num_columns is 256;
// memories are not cleared.
// ----------------------------------------------------------------------------
module sparse_triplet_to_csc_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  stc_pkg::item_t             item,
  output logic                       done,
  output stc_pkg::result_t           result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [stc_pkg::NCOL_W-1:0] cfg_data
);

  stc_pkg::dp_cmd_t    cmd;
  stc_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  stc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  stc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .done      (done),
    .result    (result)
  );

endmodule
